@@ hw/rtl/hbcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hbcr_pkg: host bridge configuration space shared definitions
// Beat types, write rule encodings, per-address write masks and the
// power-on contents of the 256-byte configuration space.
// ----------------------------------------------------------------------------
package hbcr_pkg;

  typedef enum logic { CMD_READ = 1'b0, CMD_WRITE = 1'b1 } cmd_e;

  // One bus access
  typedef struct packed {
    logic       cmd;
    logic [7:0] reg_address;
    logic [7:0] write_data;
  } in_t;

  // One access result
  typedef struct packed {
    logic [7:0]  read_data;
    logic        smi_pulse;
    logic        ext_cache_enable;
    logic        shadow_update_low;
    logic        shadow_update_high;
    logic [19:0] shadow_base;
    logic [1:0]  shadow_low_mode;
    logic [1:0]  shadow_high_mode;
    logic        smram_update;
    logic [1:0]  smram_window;
    logic        smram_open;
  } out_t;

  // How a write merges into the stored byte
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,  // read-only, write dropped
    WR_CMD   = 3'd1,  // command bytes: only bit 1 is writable
    WR_W1C   = 3'd2,  // status high byte: write one to clear
    WR_AND   = 3'd3,  // write-and
    WR_PLAIN = 3'd4   // data ANDed with a fixed mask
  } wr_kind_e;

  typedef struct packed {
    wr_kind_e   kind;
    logic [7:0] mask;
  } wr_rule_t;

  // Special register addresses
  localparam logic [7:0] ADDR_CMD_LO     = 8'h04;
  localparam logic [7:0] ADDR_CMD_HI     = 8'h05;
  localparam logic [7:0] ADDR_STATUS_HI  = 8'h07;
  localparam logic [7:0] ADDR_CACHE_CTL  = 8'h51;
  localparam logic [7:0] ADDR_SHADOW_LO  = 8'h70;
  localparam logic [7:0] ADDR_SHADOW_F   = 8'h76;
  localparam logic [7:0] ADDR_SMI_TRIG   = 8'h93;
  localparam logic [7:0] ADDR_SMI_EN     = 8'h9b;
  localparam logic [7:0] ADDR_SMI_STAT   = 8'h9d;
  localparam logic [7:0] ADDR_SMRAM      = 8'ha3;

  localparam logic [7:0] CMD_KEEP_MASK   = 8'hfd;
  localparam logic [7:0] CMD_WR_MASK     = 8'h02;
  localparam logic [7:0] STATUS_W1C_MASK = 8'hb8;
  localparam logic [7:0] SHADOW_LO_MASK  = 8'ha0;
  localparam logic [7:0] SHADOW_HI_MASK  = 8'h0a;

  localparam logic [19:0] SHADOW_BASE_C  = 20'hc0000;
  localparam logic [19:0] SHADOW_BASE_F  = 20'hf0000;

  // Write rule of each configuration byte
  function automatic wr_rule_t wr_rule(input logic [7:0] a);
    wr_rule_t r;
    r.kind = WR_PLAIN;
    r.mask = 8'hff;
    if (a == ADDR_CMD_LO || a == ADDR_CMD_HI) r.kind = WR_CMD;
    else if (a == ADDR_STATUS_HI)              r.kind = WR_W1C;
    else if (a == ADDR_SMI_STAT)               r.kind = WR_AND;
    else if (a == 8'h0d || a == 8'h51 || a == 8'h54 || a == 8'h59) r.mask = 8'hff;
    else if (a == 8'h50)                       r.mask = 8'hec;
    else if (a == 8'h52)                       r.mask = 8'hd0;
    else if (a == 8'h53)                       r.mask = 8'hfe;
    else if (a == 8'h55)                       r.mask = 8'he0;
    else if (a == 8'h56)                       r.mask = 8'h07;
    else if (a == 8'h57)                       r.mask = 8'hf8;
    else if (a == 8'h5a)                       r.mask = 8'h03;
    else if (a >= 8'h60 && a <= 8'h6b)         r.mask = 8'hff;
    else if (a >= 8'h70 && a <= 8'h75)         r.mask = 8'hee;
    else if (a == 8'h76)                       r.mask = 8'he8;
    else if (a == 8'h77)                       r.mask = 8'h0f;
    else if (a >= 8'h78 && a <= 8'h7b)         r.mask = 8'hff;
    else if (a == 8'h80)                       r.mask = 8'hfe;
    else if (a == 8'h81)                       r.mask = 8'hcc;
    else if (a >= 8'h82 && a <= 8'h86)         r.mask = 8'hff;
    else if (a == 8'h87)                       r.mask = 8'hf8;
    else if (a >= 8'h90 && a <= 8'h93)         r.mask = 8'hff;
    else if (a == 8'h94)                       r.mask = 8'hf8;
    else if (a == 8'h95 || a == 8'h96)         r.mask = 8'hfb;
    else if (a >= 8'h97 && a <= 8'h9c)         r.mask = 8'hff;
    else if (a >= 8'h9e && a <= 8'ha2)         r.mask = 8'hff;
    else if (a == ADDR_SMRAM)                  r.mask = 8'hd0;
    else                                       r.kind = WR_NONE;
    return r;
  endfunction

  // Power-on contents: ID and default bytes, zero elsewhere
  function automatic logic [7:0] init_byte(input logic [7:0] a);
    logic [7:0] b;
    case (a)
      8'h00: b = 8'h39;
      8'h01: b = 8'h10;
      8'h02: b = 8'h71;
      8'h03: b = 8'h55;
      8'h04: b = 8'h05;
      8'h07: b = 8'h02;
      8'h0b: b = 8'h06;
      8'h54: b = 8'h54;
      8'h55: b = 8'h54;
      8'h56: b = 8'h03;
      8'h60, 8'h62, 8'h64, 8'h66, 8'h68, 8'h6a: b = 8'h04;
      8'h63, 8'h67, 8'h6b: b = 8'h80;
      8'h9e, 8'h9f, 8'ha0, 8'ha2: b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/host_bridge_config_registers_top.sv @@
// ----------------------------------------------------------------------------
// host_bridge_config_registers_top: PCI host bridge configuration space
// 256-byte register file with masked writes, write-one-to-clear status,
// SMI trigger, shadow region routing reports and SMRAM window reports.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+---------------------
//  in      | to block  | in_valid_i / in_stall_o   | hbcr_pkg::in_t
//  out     | from block| out_valid_o / out_stall_i | hbcr_pkg::out_t
//
// The byte RAM is read as the beat is taken into the access stage; the merge
// and write back happen in the access stage, with the result loaded into the
// result register. One access is accepted every cycle unless the result stalls.
// Reset is immediate: per-byte valid flags fall back to the power-on table.
// A stalled result holds the access stage, which holds the input in turn.
// ----------------------------------------------------------------------------
module host_bridge_config_registers_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hbcr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hbcr_pkg::out_t out_data_o
);
  import hbcr_pkg::*;

  // Byte RAM and per-byte written flags
  logic [7:0] mem [256];
  logic [7:0] rdata_q;
  logic [255:0] vld_q;

  // Access stage
  logic       s1_valid_q;
  in_t        s1_q;

  // Last RAM write, for the access read in the same cycle
  logic       lw_valid_q;
  logic [7:0] lw_addr_q;
  logic [7:0] lw_data_q;

  // Bytes held in flops
  logic       ext_q;
  logic       smien_q;
  logic [7:0] reg9d_q;

  // Result register
  logic       out_valid_q;
  out_t       out_q;

  logic       out_free;
  logic       s1_move;
  logic       in_take;
  logic [7:0] a;
  logic [7:0] v;
  logic       wr;
  wr_rule_t   rule;
  logic [7:0] old;
  logic [7:0] nw;
  logic [7:0] diff;
  logic       mem_we;
  logic       smi;
  logic       is_shadow;
  out_t       res;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !out_free;

  assign a    = s1_q.reg_address;
  assign v    = s1_q.write_data;
  assign wr   = (s1_q.cmd == CMD_WRITE);
  assign rule = wr_rule(a);

  // Current byte: flop-held 0x9d, forwarded write, RAM, or power-on value
  always_comb begin
    if (a == ADDR_SMI_STAT) begin
      old = reg9d_q;
    end else if (lw_valid_q && lw_addr_q == a) begin
      old = lw_data_q;
    end else if (vld_q[a]) begin
      old = rdata_q;
    end else begin
      old = init_byte(a);
    end
  end

  // Merge the write data
  always_comb begin
    case (rule.kind)
      WR_CMD:   nw = (old & CMD_KEEP_MASK) | (v & CMD_WR_MASK);
      WR_W1C:   nw = old & ~(v & STATUS_W1C_MASK);
      WR_AND:   nw = old & v;
      WR_PLAIN: nw = v & rule.mask;
      default:  nw = old;
    endcase
  end

  assign diff      = old ^ nw;
  assign mem_we    = s1_move && wr && (rule.kind != WR_NONE);
  assign smi       = wr && (a == ADDR_SMI_TRIG) && smien_q && v[1];
  assign is_shadow = wr && (a >= ADDR_SHADOW_LO) && (a <= ADDR_SHADOW_F);

  // Build the result
  always_comb begin
    res = '0;
    res.read_data = wr ? 8'h00 : old;
    res.smi_pulse = smi;
    res.ext_cache_enable = (wr && a == ADDR_CACHE_CTL) ? nw[6] : ext_q;
    if (is_shadow) begin
      res.shadow_low_mode   = {nw[7], nw[5]};
      res.shadow_update_low = |(diff & SHADOW_LO_MASK);
      if (a == ADDR_SHADOW_F) begin
        res.shadow_base = SHADOW_BASE_F;
      end else begin
        res.shadow_base        = SHADOW_BASE_C + {2'b00, a[2:0], 15'd0};
        res.shadow_update_high = |(diff & SHADOW_HI_MASK);
        res.shadow_high_mode   = {nw[3], nw[1]};
      end
    end
    if (wr && a == ADDR_SMRAM) begin
      res.smram_update = 1'b1;
      res.smram_window = nw[7:6];
      res.smram_open   = nw[4];
    end
  end

  // RAM write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[a] <= nw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rdata_q <= mem[in_data_i.reg_address];
    end
  end

  // Mark written bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[a] <= 1'b1;
    end
  end

  // Track the latest write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (mem_we) begin
      lw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lw_addr_q <= a;
      lw_data_q <= nw;
    end
  end

  // Update flop-held bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q   <= 1'b0;
      smien_q <= 1'b0;
      reg9d_q <= 8'h00;
    end else if (s1_move && wr) begin
      if (a == ADDR_CACHE_CTL) begin
        ext_q <= nw[6];
      end
      if (a == ADDR_SMI_EN) begin
        smien_q <= nw[0];
      end
      if (a == ADDR_SMI_STAT) begin
        reg9d_q <= nw;
      end else if (smi) begin
        reg9d_q <= reg9d_q | 8'h01;
      end
    end
  end

  // Advance the access stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
  end

  // Hold or load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
